// ===== sv/tmes_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tmes_pkg;

  // Request codes carried in tuser
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;

  // Result kinds carried in tuser
  localparam logic [2:0] KIND_QUEUED   = 3'd0;
  localparam logic [2:0] KIND_FULL     = 3'd1;
  localparam logic [2:0] KIND_REALTIME = 3'd2;
  localparam logic [2:0] KIND_EVENT    = 3'd3;
  localparam logic [2:0] KIND_NOTHING  = 3'd4;

  // Configuration register indexes
  localparam logic CFG_DELAY_MODE = 1'b0;
  localparam logic CFG_SPB_Q8     = 1'b1;

  localparam logic [1:0]  MODE_IMMEDIATE  = 2'd0;
  localparam logic [1:0]  DELAY_MODE_RST  = 2'd1;
  localparam logic [15:0] SPB_Q8_RST      = 16'd2097;

  localparam int MSG_W   = 24;
  localparam int TIME_W  = 32;
  localparam int SPB_W   = 16;
  localparam int PROD_W  = SPB_W + 2;
  localparam int XFER_W  = PROD_W - 8;

  // One queue entry: due time above the message
  typedef struct packed {
    logic [TIME_W-1:0] due;
    logic [MSG_W-1:0]  msg;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_TICK,
    ST_FLUSH,
    ST_SIMPLE
  } state_t;

  // Bytes on the serial link for a status byte
  function automatic logic [1:0] msg_length(input logic [7:0] st);
    logic [1:0] len;
    begin
      if (st[7:4] == 4'hF) begin
        case (st[3:0])
          4'h1, 4'h3: len = 2'd2;
          4'h2:       len = 2'd3;
          default:    len = 2'd1;
        endcase
      end else if (st[7:5] == 3'b110) begin
        len = 2'd2;
      end else begin
        len = 2'd3;
      end
      return len;
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/tmes_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tmes_store
  import tmes_pkg::*;
#(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire entry_t            wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output entry_t                 rdata
);

  entry_t mem [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/tmes_timing.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tmes_timing
  import tmes_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic [7:0]        status,
  input  wire logic [SPB_W-1:0]  spb_q8,
  input  wire logic [TIME_W-1:0] push_time,
  input  wire logic [TIME_W-1:0] last_arrival,
  output logic [TIME_W-1:0]      due
);

  logic [PROD_W-1:0] prod;
  logic [XFER_W-1:0] xfer;
  logic [TIME_W-1:0] gap;
  logic [TIME_W-1:0] base;

  // Link transfer time, truncated to whole samples
  assign prod = PROD_W'(msg_length(status)) * PROD_W'(spb_q8);

  always_ff @(posedge clk) begin
    if (load) begin
      xfer <= prod[PROD_W-1:8];
    end
  end

  // Never start before the previous arrival (wrapping order)
  assign gap  = push_time - last_arrival;
  assign base = gap[TIME_W-1] ? last_arrival : push_time;
  assign due  = base + TIME_W'(xfer);

endmodule
`default_nettype wire

// ===== sv/timestamped_midi_event_scheduler_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Push, tick and type-three requests: each goes from idle to its working state, which
// loads the result once the output is free and returns to idle for the next request.
// Flush: one event per cycle while the result register is free (memory read port).
// A request is taken once the previous last result sits in the result register.
// Reset (rst, synchronous): queue empty, sample counter and arrival time zero,
// delay mode 1, samples per byte 2097/256. Queue memory is not cleared.
module timestamped_midi_event_scheduler_unit
  import tmes_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration writes
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // Requests
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // message[23:0], event_time[55:24],
                                          // use_current_time[56], zero pad
  input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
  // Results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // status_nibble[3:0], channel[7:4],
                                          // data_one[14:8], data_two[21:15],
                                          // realtime_byte[29:22], zero pad
  output logic [2:0]       m_axis_tuser,  // result_kind[2:0]
  output logic             m_axis_tlast   // last
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(QUEUE_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_MAX) ? '0 : p + PTR_W'(1);
  endfunction

  // Input field views
  logic [MSG_W-1:0]  in_msg;
  logic [TIME_W-1:0] in_time;
  logic              in_use_now;
  logic              in_accept;

  assign in_msg     = s_axis_tdata[23:0];
  assign in_time    = s_axis_tdata[55:24];
  assign in_use_now = s_axis_tdata[56];

  // Registers
  state_t            state, state_next;
  logic [1:0]        delay_mode;
  logic [SPB_W-1:0]  samples_per_byte_q8;
  logic [PTR_W-1:0]  read_pointer, read_pointer_next;
  logic [PTR_W-1:0]  write_pointer;
  logic [TIME_W-1:0] last_arrival_time, last_arrival_time_next;
  logic [TIME_W-1:0] sample_counter;
  logic [MSG_W-1:0]  req_msg;
  logic [TIME_W-1:0] req_time;
  logic [2:0]        simple_kind;
  logic [7:0]        simple_rt;

  // Control from the state decode
  logic              out_free;
  logic              out_load;
  logic [2:0]        out_kind;
  logic [MSG_W-1:0]  out_msg;
  logic [7:0]        out_rt;
  logic              out_last;
  logic              mem_we;
  logic              rp_adv;
  logic              lat_we;
  logic              sc_inc;

  logic [PTR_W-1:0]  rp_inc;
  logic [PTR_W-1:0]  wp_inc;
  logic              q_empty;
  logic              q_full;
  logic              head_due;
  logic [TIME_W-1:0] head_gap;
  logic [TIME_W-1:0] push_due;
  entry_t            head;
  entry_t            wr_entry;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  assign rp_inc   = ring_next(read_pointer);
  assign wp_inc   = ring_next(write_pointer);
  assign q_empty  = (read_pointer == write_pointer);
  assign q_full   = (wp_inc == read_pointer);
  assign head_gap = head.due - sample_counter;
  assign head_due = (head_gap == '0) || head_gap[TIME_W-1];

  // Transfer delay and due time
  tmes_timing u_timing (
    .clk          (clk),
    .load         (in_accept),
    .status       (in_msg[7:0]),
    .spb_q8       (samples_per_byte_q8),
    .push_time    (req_time),
    .last_arrival (last_arrival_time),
    .due          (push_due)
  );

  // Queue memory; read address is the next head pointer so registered data is the head
  assign read_pointer_next = rp_adv ? rp_inc : read_pointer;
  assign wr_entry.due = (delay_mode == MODE_IMMEDIATE) ? req_time : push_due;
  assign wr_entry.msg = req_msg;

  tmes_store #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (PTR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (write_pointer),
    .wdata (wr_entry),
    .raddr (read_pointer_next),
    .rdata (head)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          case (s_axis_tuser)
            REQ_PUSH:  state_next = (in_msg[7:3] == 5'b11111) ? ST_SIMPLE : ST_PUSH;
            REQ_TICK:  state_next = ST_TICK;
            REQ_FLUSH: state_next = ST_FLUSH;
            default:   state_next = ST_SIMPLE;
          endcase
        end
      end
      ST_PUSH, ST_TICK, ST_SIMPLE: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_FLUSH: begin
        if (out_free && out_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    out_load = 1'b0;
    out_kind = KIND_NOTHING;
    out_msg  = '0;
    out_rt   = '0;
    out_last = 1'b0;
    mem_we   = 1'b0;
    rp_adv   = 1'b0;
    lat_we   = 1'b0;
    sc_inc   = 1'b0;
    last_arrival_time_next = sample_counter;
    case (state)
      ST_PUSH: begin
        out_last = 1'b1;
        last_arrival_time_next = push_due;
        if (out_free) begin
          out_load = 1'b1;
          lat_we   = (delay_mode != MODE_IMMEDIATE);
          if (q_full) begin
            out_kind = KIND_FULL;
          end else begin
            out_kind = KIND_QUEUED;
            mem_we   = 1'b1;
          end
        end
      end
      ST_TICK: begin
        out_last = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          sc_inc   = 1'b1;
          if (!q_empty && head_due) begin
            out_kind = KIND_EVENT;
            out_msg  = head.msg;
            rp_adv   = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        out_last = q_empty || (rp_inc == write_pointer);
        if (out_free) begin
          out_load = 1'b1;
          lat_we   = out_last;
          if (!q_empty) begin
            out_kind = KIND_EVENT;
            out_msg  = head.msg;
            rp_adv   = 1'b1;
          end
        end
      end
      ST_SIMPLE: begin
        out_last = 1'b1;
        out_kind = simple_kind;
        out_rt   = simple_rt;
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      delay_mode          <= DELAY_MODE_RST;
      samples_per_byte_q8 <= SPB_Q8_RST;
      read_pointer        <= '0;
      write_pointer       <= '0;
      last_arrival_time   <= '0;
      sample_counter      <= '0;
      m_axis_tvalid       <= 1'b0;
    end else begin
      state        <= state_next;
      read_pointer <= read_pointer_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DELAY_MODE: delay_mode          <= cfg_data[1:0];
          CFG_SPB_Q8:     samples_per_byte_q8 <= cfg_data;
          default: ;
        endcase
      end
      if (mem_we) write_pointer <= wp_inc;
      if (lat_we) last_arrival_time <= last_arrival_time_next;
      if (sc_inc) sample_counter <= sample_counter + TIME_W'(1);
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_msg     <= in_msg;
      req_time    <= in_use_now ? sample_counter : in_time;
      simple_kind <= (s_axis_tuser == REQ_PUSH) ? KIND_REALTIME : KIND_NOTHING;
      simple_rt   <= (s_axis_tuser == REQ_PUSH) ? in_msg[7:0] : 8'd0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tuser        <= out_kind;
      m_axis_tlast        <= out_last;
      m_axis_tdata[3:0]   <= out_msg[7:4];
      m_axis_tdata[7:4]   <= out_msg[3:0];
      m_axis_tdata[14:8]  <= out_msg[14:8];
      m_axis_tdata[21:15] <= out_msg[22:16];
      m_axis_tdata[29:22] <= out_rt;
      m_axis_tdata[31:30] <= 2'b00;
    end
  end

`ifndef NO_ASSERTIONS
  // Never write into the slot that must stay free
  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (ring_next(write_pointer) != read_pointer))
    else $error("queue written while full");

  // A tick always advances the sample counter by one
  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TICK && out_free) |=> (sample_counter == $past(sample_counter) + 32'd1))
    else $error("tick did not advance sample counter");

  // The final flush result leaves the queue empty
  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && out_free && out_last) |=> (read_pointer == write_pointer))
    else $error("flush left events queued");

  // No request is taken while a request is still being worked on
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state != ST_IDLE) && !s_axis_tready)
    else $error("request accepted during processing");
`endif

endmodule
`default_nettype wire
